/* src/ttc_pkg.sv */
// Shared types, constants and lookup functions for the tile terrain classifier.
// No dependencies; imported by ttc_lane, ttc_merge and the top level.
package ttc_pkg;

	localparam int NUM_PALETTES = 8;
	localparam int NUM_LANES    = 4;
	localparam int COLOUR_W     = 15;
	localparam int PALETTE_W    = NUM_LANES * COLOUR_W;
	localparam int CFG_INDEX_W  = $clog2(NUM_PALETTES);
	localparam int ROWS         = 8;
	localparam int PIXELS       = 64;
	localparam int CH_MASK      = 'h1F;

	// luma weights and the reciprocal of 100 (exact for sums up to 25500)
	localparam int LUMA_RED    = 30;
	localparam int LUMA_GREEN  = 59;
	localparam int LUMA_BLUE   = 11;
	localparam int LUMA_RECIP  = 5243;
	localparam int LUMA_SHIFT  = 19;

	// rule thresholds
	localparam int DARK_LUMA     = 72;
	localparam int WATER_BLUE    = 28;
	localparam int WATER_LUMA    = 190;
	localparam int HIGH_DARK     = 45;
	localparam int HIGH_CONTRAST = 90;
	localparam int TREE_DARK     = 30;
	localparam int TREE_GREEN    = 18;
	localparam int MID_CONTRAST  = 120;
	localparam int MID_DARK      = 18;
	localparam int LOW_GREEN     = 22;
	localparam int LOW_CONTRAST  = 76;
	localparam int LEAFY_GREEN   = 12;

	typedef enum logic [2:0] {
		HEIGHT_FLOOR = 3'd0,
		HEIGHT_LOW   = 3'd1,
		HEIGHT_MID   = 3'd2,
		HEIGHT_HIGH  = 3'd3,
		HEIGHT_WATER = 3'd4
	} height_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// what one colour lane hands to the merge stage
	typedef struct packed {
		logic [6:0]  count;
		logic [7:0]  luma;
		logic [13:0] red_w;
		logic [13:0] green_w;
		logic [13:0] blue_w;
	} lane_t;

	// x*255/31, truncated
	localparam logic [7:0] EXPAND5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	function automatic logic [7:0] expand5(input logic [4:0] v);
		return EXPAND5[v];
	endfunction

	// pixels of one row that carry colour index idx
	function automatic logic [3:0] row_count(input logic [7:0] lo, input logic [7:0] hi,
			input logic [1:0] idx);
		logic [7:0] hit;
		logic [3:0] n;
		hit = (idx[0] ? lo : ~lo) & (idx[1] ? hi : ~hi);
		n = '0;
		for (int b = 0; b < 8; b++) begin
			n = n + 4'(hit[b]);
		end
		return n;
	endfunction

endpackage

/* src/ttc_in_if.sv */
// Input channel of the tile terrain classifier: one tile pattern and palette number per item.
// Depends on nothing.
interface ttc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] pattern_first_half;
	logic [63:0] pattern_second_half;
	logic [2:0]  palette_select;

	modport source(output valid, pattern_first_half, pattern_second_half, palette_select,
		input ready);
	modport sink(input valid, pattern_first_half, pattern_second_half, palette_select,
		output ready);
endinterface

/* src/ttc_out_if.sv */
// Output channel of the tile terrain classifier: height class and leafy flag per item.
// Depends on nothing.
interface ttc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] height_class;
	logic       leafy;

	modport source(output valid, height_class, leafy, input ready);
	modport sink(input valid, height_class, leafy, output ready);
endinterface

/* src/ttc_lane.sv */
// One colour lane: pixel count, channel expansion and luma for a single colour index.
// Depends on ttc_pkg.
module ttc_lane import ttc_pkg::*; (
	input  logic                clk,
	input  pipe_en_t            en,
	input  logic [1:0]          colour_index,
	input  logic [127:0]        pattern,
	input  logic [COLOUR_W-1:0] colour,
	output lane_t               lane
);

	logic [6:0]  count_c;
	logic [7:0]  red_c, green_c, blue_c;
	logic [14:0] wsum_c;

	logic [6:0]  count_s1;
	logic [7:0]  red_s1, green_s1, blue_s1;
	logic [14:0] wsum_s1;
	logic [27:0] luma_prod;
	lane_t       lane_s2;

	always_comb begin
		count_c = '0;
		for (int r = 0; r < ROWS; r++) begin
			count_c = count_c + 7'(row_count(pattern[16*r +: 8], pattern[16*r+8 +: 8],
				colour_index));
		end
	end

	assign red_c   = expand5(colour[4:0]);
	assign green_c = expand5(colour[9:5]);
	assign blue_c  = expand5(colour[14:10]);
	assign wsum_c  = 15'(red_c) * 15'(LUMA_RED) + 15'(green_c) * 15'(LUMA_GREEN)
		+ 15'(blue_c) * 15'(LUMA_BLUE);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			count_s1 <= count_c;
			red_s1   <= red_c;
			green_s1 <= green_c;
			blue_s1  <= blue_c;
			wsum_s1  <= wsum_c;
		end
	end

	// divide by 100 through the reciprocal
	assign luma_prod = 28'(wsum_s1) * 28'(LUMA_RECIP);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			lane_s2.count   <= count_s1;
			lane_s2.luma    <= luma_prod[LUMA_SHIFT +: 8];
			lane_s2.red_w   <= 14'(red_s1) * 14'(count_s1);
			lane_s2.green_w <= 14'(green_s1) * 14'(count_s1);
			lane_s2.blue_w  <= 14'(blue_s1) * 14'(count_s1);
		end
	end

	assign lane = lane_s2;

endmodule

/* src/ttc_merge.sv */
// Merge stage: combines the four lanes into tile features, then runs the rule chain.
// Depends on ttc_pkg.
module ttc_merge import ttc_pkg::*; (
	input  logic                  clk,
	input  pipe_en_t              en,
	input  lane_t [NUM_LANES-1:0] lanes,
	output logic [2:0]            height_class,
	output logic                  leafy
);

	localparam logic [13:0] WATER_LUMA_SUM = 14'(WATER_LUMA * PIXELS);
	localparam logic signed [15:0] WATER_DIFF = 16'((WATER_BLUE + 1) * PIXELS);
	localparam logic signed [15:0] TREE_DIFF  = 16'((TREE_GREEN + 1) * PIXELS);
	localparam logic signed [15:0] LOW_DIFF   = 16'((LOW_GREEN + 1) * PIXELS);
	localparam logic signed [15:0] LEAFY_DIFF = 16'((LEAFY_GREEN + 1) * PIXELS);
	localparam logic [12:0] HIGH_DARK_SC = 13'(HIGH_DARK * PIXELS);
	localparam logic [12:0] TREE_DARK_SC = 13'(TREE_DARK * PIXELS);
	localparam logic [12:0] MID_DARK_SC  = 13'(MID_DARK * PIXELS);

	logic [13:0] luma_sum_c, rs_c, gs_c, bs_c;
	logic [7:0]  min_c, max_c;
	logic [6:0]  dark_c;

	logic [13:0] luma_sum_s3, rs_s3, gs_s3, bs_s3;
	logic [7:0]  contrast_s3;
	logic [6:0]  dark_s3;

	logic [13:0]        half_rg, half_rb;
	logic signed [15:0] blue_diff, green_diff;
	logic [12:0]        dark_sc;
	height_t            height_c;
	height_t            height_s4;
	logic               leafy_s4;

	always_comb begin
		logic [15:0] acc_l, acc_r, acc_g, acc_b;
		logic [7:0]  acc_d;
		acc_l = '0;
		acc_r = '0;
		acc_g = '0;
		acc_b = '0;
		acc_d = '0;
		min_c = 8'hFF;
		max_c = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			acc_l = acc_l + 16'(14'(lanes[i].luma) * 14'(lanes[i].count));
			acc_r = acc_r + 16'(lanes[i].red_w);
			acc_g = acc_g + 16'(lanes[i].green_w);
			acc_b = acc_b + 16'(lanes[i].blue_w);
			// unused colours stay out of contrast; their count adds nothing elsewhere
			if (lanes[i].count != '0) begin
				if (lanes[i].luma < min_c) min_c = lanes[i].luma;
				if (lanes[i].luma > max_c) max_c = lanes[i].luma;
			end
			if (lanes[i].luma < 8'(DARK_LUMA)) acc_d = acc_d + 8'(lanes[i].count);
		end
		luma_sum_c = acc_l[13:0];
		rs_c       = acc_r[13:0];
		gs_c       = acc_g[13:0];
		bs_c       = acc_b[13:0];
		dark_c     = acc_d[6:0];
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			luma_sum_s3 <= luma_sum_c;
			rs_s3       <= rs_c;
			gs_s3       <= gs_c;
			bs_s3       <= bs_c;
			contrast_s3 <= max_c - min_c;
			dark_s3     <= dark_c;
		end
	end

	// bias/64 > T with truncation toward zero is diff >= 64*(T+1)
	assign half_rg    = 14'((15'(rs_s3) + 15'(gs_s3)) >> 1);
	assign half_rb    = 14'((15'(rs_s3) + 15'(bs_s3)) >> 1);
	assign blue_diff  = $signed(16'(bs_s3) - 16'(half_rg));
	assign green_diff = $signed(16'(gs_s3) - 16'(half_rb));
	assign dark_sc    = 13'(dark_s3) * 13'd100;

	always_comb begin
		if (blue_diff >= WATER_DIFF && luma_sum_s3 < WATER_LUMA_SUM)
			height_c = HEIGHT_WATER;
		else if (dark_sc >= HIGH_DARK_SC && contrast_s3 > 8'(HIGH_CONTRAST))
			height_c = HEIGHT_HIGH;
		else if (dark_sc >= TREE_DARK_SC && green_diff >= TREE_DIFF)
			height_c = HEIGHT_HIGH;
		else if (contrast_s3 > 8'(MID_CONTRAST) && dark_sc >= MID_DARK_SC)
			height_c = HEIGHT_MID;
		else if (green_diff >= LOW_DIFF && contrast_s3 > 8'(LOW_CONTRAST))
			height_c = HEIGHT_LOW;
		else
			height_c = HEIGHT_FLOOR;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			height_s4 <= height_c;
			leafy_s4  <= (green_diff >= LEAFY_DIFF);
		end
	end

	assign height_class = height_s4;
	assign leafy        = leafy_s4;

endmodule

/* src/tile_terrain_classifier.sv */
// Top level of the tile terrain classifier: palette registers, lane array, merge, flow control.
// Depends on ttc_pkg, ttc_in_if, ttc_out_if, ttc_lane and ttc_merge.

// Each item is one 8x8 two-plane tile and a palette number; the block returns one item
// per tile with a height class and a leafy flag. Throughput is one tile per clock while
// result.ready is high; a stall on result.ready holds the stages. A tile passes through
// four register stages from input to output.
// Four colour lanes, one per colour index, count their pixels and expand and weigh their
// palette colour side by side (stages one and two); the merge unit sums the lanes into
// luma, contrast, dark count and channel sums (stage three) and runs the priority rule
// chain into the output register (stage four). Every stage has its own valid bit and
// loads whenever it is empty or its successor moves, so bubbles close up under stall.
// The user writes palette registers via cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module tile_terrain_classifier import ttc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [PALETTE_W-1:0]   cfg_data,
	ttc_in_if.sink                 tile,
	ttc_out_if.source              result
);

	logic [PALETTE_W-1:0] palette_q [NUM_PALETTES];
	logic [PALETTE_W-1:0] sel_palette;
	logic [127:0]         pattern;
	lane_t [NUM_LANES-1:0] lanes;
	pipe_en_t             en;
	logic                 valid_s1, valid_s2, valid_s3, valid_s4;

	// palette registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PALETTES; i++) palette_q[i] <= '0;
		end else if (cfg_we) begin
			palette_q[cfg_index] <= cfg_data;
		end
	end

	assign sel_palette = palette_q[tile.palette_select];
	assign pattern     = {tile.pattern_second_half, tile.pattern_first_half};

	// per-stage flow control: a stage loads when empty or when its successor moves
	assign en.s4      = !valid_s4 || result.ready;
	assign en.s3      = !valid_s3 || en.s4;
	assign en.s2      = !valid_s2 || en.s3;
	assign en.s1      = !valid_s1 || en.s2;
	assign tile.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= tile.valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	// one lane per colour index
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		ttc_lane u_lane (
			.clk          (clk),
			.en           (en),
			.colour_index (2'(g)),
			.pattern      (pattern),
			.colour       (sel_palette[COLOUR_W*g +: COLOUR_W]),
			.lane         (lanes[g])
		);
	end

	ttc_merge u_merge (
		.clk          (clk),
		.en           (en),
		.lanes        (lanes),
		.height_class (result.height_class),
		.leafy        (result.leafy)
	);

	assign result.valid = valid_s4;

`ifndef SYNTHESIS
	// an accepted tile always occupies stage one next
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(tile.valid && tile.ready) |=> valid_s1)
		else $error("accepted tile lost before stage one");

	// a blocked stage three keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en.s3) |=> valid_s3)
		else $error("stage three dropped an item under stall");

	// low class needs green bias above 22, which implies leafy
	a_low_is_leafy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.height_class == 3'(HEIGHT_LOW)) |-> result.leafy)
		else $error("low class without leafy flag");

	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.height_class <= 3'(HEIGHT_WATER)))
		else $error("height class out of range");
`endif

endmodule
